[rtl/lpd_pkg.sv]
// Shared types and constants of the length-prefix deframer.
`default_nettype none

package lpd_pkg;

  localparam int unsigned LenW = 32;
  localparam int unsigned ByteW = 8;
  localparam logic [LenW-1:0] MaxLenReset = 32'd65535;

  typedef struct packed {
    logic [ByteW-1:0] payload_byte;
    logic             first_byte;
    logic             last_byte;
    logic             empty_packet;
    logic             length_error;
    logic [LenW-1:0]  packet_length;
  } result_t;

endpackage

`default_nettype wire

[rtl/lpd_core.sv]
// Header gathering, payload counting and result forming for one beat.
`default_nettype none

module lpd_core
  import lpd_pkg::*;
#(
  parameter int unsigned HEADER_BYTES = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [LenW-1:0]  cfg_wdata_i,
  input  wire logic             accept_i,
  input  wire logic [ByteW-1:0] data_byte_i,
  output logic                  res_valid_o,
  output result_t               res_o
);

  localparam int unsigned CntW = (HEADER_BYTES > 1) ? $clog2(HEADER_BYTES) : 1;
  localparam logic [CntW-1:0] HdrLast = CntW'(HEADER_BYTES - 1);

  logic [LenW-1:0] max_len_q;
  logic            in_payload_q, in_payload_d;
  logic [CntW-1:0] hdr_cnt_q, hdr_cnt_d;
  logic [LenW-1:0] length_q, length_d;
  logic [LenW-1:0] bytes_left_q, bytes_left_d;
  logic            first_q, first_d;

  logic [LenW-1:0] shifted;
  logic [LenW-1:0] len_full;
  logic            last_pl;

  assign shifted  = {{(LenW-ByteW){1'b0}}, data_byte_i} << {hdr_cnt_q, 3'b000};
  assign len_full = length_q | shifted;
  assign last_pl  = (bytes_left_q[LenW-1:1] == '0);

  always_comb begin
    in_payload_d = in_payload_q;
    hdr_cnt_d    = hdr_cnt_q;
    length_d     = length_q;
    bytes_left_d = bytes_left_q;
    first_d      = first_q;
    res_valid_o  = 1'b0;
    res_o        = '0;
    if (!in_payload_q) begin
      if (hdr_cnt_q == HdrLast) begin
        if (len_full == '0) begin
          res_valid_o        = 1'b1;
          res_o.first_byte   = 1'b1;
          res_o.last_byte    = 1'b1;
          res_o.empty_packet = 1'b1;
          hdr_cnt_d          = '0;
          length_d           = '0;
        end else begin
          in_payload_d = 1'b1;
          length_d     = len_full;
          bytes_left_d = len_full;
          first_d      = 1'b1;
          if (len_full > max_len_q) begin
            res_valid_o         = 1'b1;
            res_o.length_error  = 1'b1;
            res_o.packet_length = len_full;
          end
        end
      end else begin
        hdr_cnt_d = hdr_cnt_q + 1'b1;
        length_d  = len_full;
      end
    end else begin
      res_valid_o         = 1'b1;
      res_o.payload_byte  = data_byte_i;
      res_o.first_byte    = first_q;
      res_o.last_byte     = last_pl;
      res_o.packet_length = length_q;
      first_d             = 1'b0;
      if (last_pl) begin
        in_payload_d = 1'b0;
        hdr_cnt_d    = '0;
        length_d     = '0;
        bytes_left_d = '0;
      end else begin
        bytes_left_d = bytes_left_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MaxLenReset;
    end else if (cfg_we_i) begin
      max_len_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_payload_q <= 1'b0;
      hdr_cnt_q    <= '0;
      length_q     <= '0;
      bytes_left_q <= '0;
      first_q      <= 1'b0;
    end else if (accept_i) begin
      in_payload_q <= in_payload_d;
      hdr_cnt_q    <= hdr_cnt_d;
      length_q     <= length_d;
      bytes_left_q <= bytes_left_d;
      first_q      <= first_d;
    end
  end

endmodule

`default_nettype wire

[rtl/lpd_out_reg.sv]
// Output register holding one result beat toward the receiver.
`default_nettype none

module lpd_out_reg
  import lpd_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    load_i,
  input  wire logic    valid_i,
  input  wire result_t data_i,
  output logic         ready_o,
  output logic         valid_o,
  output result_t      data_o,
  input  wire logic    ready_i
);

  logic    valid_q;
  result_t data_q;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= load_i && valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && load_i && valid_i) begin
      data_q <= data_i;
    end
  end

endmodule

`default_nettype wire

[rtl/length_prefix_deframer.sv]
// Top level of the length-prefix deframer.
//
// Input channel: one raw stream byte per beat (in_valid_i/in_ready_o, data_byte_i).
// Each packet is a little-endian length header of HEADER_BYTES bytes followed by
// that many payload bytes. Header bytes give no result; each payload byte gives
// one result beat with first/last marks and the announced length. A zero length
// gives one empty beat; a length above max_length gives one error beat, and the
// payload is still passed through.
// Output channel: out_valid_o/out_ready_i with one port per result field.
// Config: cfg_we_i/cfg_wdata_i write max_length; write while idle.
// A result is registered and appears in the cycle after the byte that causes it.
// Throughput: one byte per cycle; header, compare and counter logic finish in
// the cycle the byte is taken, and the output register holds the result.
// When the receiver stalls with a result held, in_ready_o drops until that
// result is taken; otherwise a new byte is taken in the same cycle.
// Reset: framing restarts at a header, the output register empties and
// max_length returns to 65535.
`default_nettype none

module length_prefix_deframer
  import lpd_pkg::*;
#(
  parameter int unsigned HEADER_BYTES = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [LenW-1:0]  cfg_wdata_i,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [ByteW-1:0] data_byte_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [ByteW-1:0]      payload_byte_o,
  output logic                  first_byte_o,
  output logic                  last_byte_o,
  output logic                  empty_packet_o,
  output logic                  length_error_o,
  output logic [LenW-1:0]       packet_length_o
);

  logic    accept;
  logic    res_valid;
  result_t res;
  result_t out_data;

  assign accept = in_valid_i && in_ready_o;

  lpd_core #(
    .HEADER_BYTES(HEADER_BYTES)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .accept_i   (accept),
    .data_byte_i(data_byte_i),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  lpd_out_reg u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (in_valid_i),
    .valid_i(res_valid),
    .data_i (res),
    .ready_o(in_ready_o),
    .valid_o(out_valid_o),
    .data_o (out_data),
    .ready_i(out_ready_i)
  );

  assign payload_byte_o  = out_data.payload_byte;
  assign first_byte_o    = out_data.first_byte;
  assign last_byte_o     = out_data.last_byte;
  assign empty_packet_o  = out_data.empty_packet;
  assign length_error_o  = out_data.length_error;
  assign packet_length_o = out_data.packet_length;

endmodule

`default_nettype wire

[rtl/lpd_checker.sv]
// Port-level assertions for the length-prefix deframer, bound to the top level.
`default_nettype none

module lpd_port_checker
  import lpd_pkg::*;
(
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             in_ready_o,
  input wire logic             out_valid_o,
  input wire logic             out_ready_i,
  input wire logic [ByteW-1:0] payload_byte_o,
  input wire logic             first_byte_o,
  input wire logic             last_byte_o,
  input wire logic             empty_packet_o,
  input wire logic             length_error_o,
  input wire logic [LenW-1:0]  packet_length_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(payload_byte_o)
      && $stable(packet_length_o) && $stable(first_byte_o) && $stable(last_byte_o))
    else $error("stalled result beat changed");

  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output register");

  a_empty_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && empty_packet_o |-> first_byte_o && last_byte_o && !length_error_o
      && payload_byte_o == '0 && packet_length_o == '0)
    else $error("malformed empty beat");

  a_error_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && length_error_o |-> !first_byte_o && !last_byte_o && !empty_packet_o
      && payload_byte_o == '0 && packet_length_o != '0)
    else $error("malformed error beat");

  a_single_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && first_byte_o && last_byte_o && !empty_packet_o
      |-> packet_length_o == 32'd1)
    else $error("first and last on a packet longer than one byte");

endmodule

bind length_prefix_deframer lpd_port_checker u_lpd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .payload_byte_o (payload_byte_o),
  .first_byte_o   (first_byte_o),
  .last_byte_o    (last_byte_o),
  .empty_packet_o (empty_packet_o),
  .length_error_o (length_error_o),
  .packet_length_o(packet_length_o)
);

`default_nettype wire
